// ===== rtl/core/wsed_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the windowed strict extremum detector.
// No dependencies; every other file of the block imports this package.
package wsed_pkg;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_MAX_LENGTH = 4096;

    localparam int SAMPLE_W  = 32;
    localparam int POS_W     = 12;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

    // Control of the left-verdict delay line.
    typedef struct packed {
        logic shift;
        logic clear;
    } chain_ctl_t;

endpackage

// ===== rtl/core/windowed_strict_extremum_detector_top.sv =====
`timescale 1ns / 1ps
// Windowed strict extremum detector, top level.
// Depends on wsed_pkg, wsed_chain and wsed_cell.
//
// Profile samples enter on the s_ channel (tdata = sample, tlast = end of
// profile). Verdicts leave on the m_ channel, one item per position:
// tdata = {pad, is_peak, position}, tlast = verdict for the last position.
// A verdict for position i is produced when sample i+W is accepted, where W is
// the window clamped to MAX_WINDOW; it reaches m_tvalid in the next cycle.
// A new sample can be taken in any cycle in which s_tready is high.
// The end of a profile copies the delay line into a flush register and then
// emits min(j, W)+1 verdicts, one per cycle while the queue is not full, from a
// two-entry output queue; s_tready is low until the flush ends. The delay line
// is a row of one-bit cells, so its depth sets the longest flush.
// When the receiver stalls, one more sample is still taken (the queue has two
// entries); after that s_tready falls until a verdict is taken.
// Reset (aresetn low, synchronous) empties the queue, clears the profile
// state and sets window to 1 and mode to minima. The user writes registers through
// cfg_we/cfg_index/cfg_wdata only while no profile item is in flight (not enforced).
module windowed_strict_extremum_detector_top import wsed_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Sample input.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] sample
    input  logic                 s_tlast,
    // Verdict output.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] position, [12] is_peak, rest zero
    output logic                 m_tlast
);

    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_LENGTH);
    localparam int CW    = (CNT_W > WW) ? CNT_W : WW;

    // Configuration.
    logic [CFG_W-1:0] window_reg;
    logic             mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= CFG_W'(1);
            mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW: window_reg <= cfg_wdata;
                REG_MODE:   mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Profile state.
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [WW-1:0]              fall_reg;
    logic [WW-1:0]              rise_reg;

    // Flush state.
    logic                  flushing_reg;
    logic [WW-1:0]         flush_d_reg;
    logic [CNT_W-1:0]      flush_j_reg;
    logic [WW-1:0]         flush_away_reg;
    logic [MAX_WINDOW-1:0] flush_taps_reg;

    // Output queue.
    logic [POS_W-1:0] q_pos_reg  [2];
    logic             q_peak_reg [2];
    logic             q_fin_reg  [2];
    logic             head_reg;
    logic [1:0]       qcnt_reg;

    logic signed [SAMPLE_W-1:0] sample;
    logic                  s_fire, m_fire, first, end_item;
    logic [WW-1:0]         w, fall_next, rise_next, into, away, lim, w_m1, d_m1;
    logic [CW-1:0]         jx, wx;
    logic                  cur_left, l_now, emit_now, flush_fire, push;
    logic [MAX_WINDOW-1:0] taps;
    chain_ctl_t            chain_ctl;
    logic [POS_W-1:0]      push_pos;
    logic                  push_peak, push_fin, wr_idx;

    assign sample = s_tdata[SAMPLE_W-1:0];
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign first  = (count_reg == '0);

    assign w  = (int'(window_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(window_reg);
    assign jx = CW'(count_reg);
    assign wx = CW'(w);

    // Strict run counters, saturating at the largest window.
    always_comb begin
        if (first || !(sample < prev_reg)) begin
            fall_next = '0;
        end else if (fall_reg >= WW'(MAX_WINDOW)) begin
            fall_next = WW'(MAX_WINDOW);
        end else begin
            fall_next = fall_reg + 1'b1;
        end
        if (first || !(sample > prev_reg)) begin
            rise_next = '0;
        end else if (rise_reg >= WW'(MAX_WINDOW)) begin
            rise_next = WW'(MAX_WINDOW);
        end else begin
            rise_next = rise_reg + 1'b1;
        end
    end

    assign into     = mode_reg ? rise_next : fall_next;
    assign away     = mode_reg ? fall_next : rise_next;
    assign lim      = (jx < wx) ? WW'(jx) : w;
    assign cur_left = !first && (into >= lim);
    assign end_item = s_tlast || (count_reg >= CNT_W'(MAX_LENGTH - 1));

    assign chain_ctl.shift = s_fire && !end_item;
    assign chain_ctl.clear = s_fire && end_item;

    wsed_chain #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (chain_ctl),
        .left_in (cur_left),
        .taps    (taps)
    );

    // Steady-state verdict for position j-W.
    assign w_m1     = w - 1'b1;
    assign l_now    = (w == '0) ? cur_left : taps[w_m1[IW-1:0]];
    assign emit_now = s_fire && !end_item && (jx >= wx);

    // Flush verdict for position j-d.
    assign d_m1       = flush_d_reg - 1'b1;
    assign flush_fire = flushing_reg && (qcnt_reg != 2'd2);

    always_comb begin
        if (flush_fire) begin
            push_pos  = POS_W'(CW'(flush_j_reg) - CW'(flush_d_reg));
            push_peak = (flush_d_reg != '0) && flush_taps_reg[d_m1[IW-1:0]]
                        && (flush_away_reg >= flush_d_reg);
            push_fin  = (flush_d_reg == '0);
        end else begin
            push_pos  = POS_W'(jx - wx);
            push_peak = l_now && (away >= w);
            push_fin  = 1'b0;
        end
    end

    assign push     = emit_now || flush_fire;
    assign s_tready = !flushing_reg && (qcnt_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            fall_reg     <= '0;
            rise_reg     <= '0;
            flushing_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                if (end_item) begin
                    count_reg    <= '0;
                    fall_reg     <= '0;
                    rise_reg     <= '0;
                    flushing_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    fall_reg  <= fall_next;
                    rise_reg  <= rise_next;
                end
            end else if (flush_fire && (flush_d_reg == '0)) begin
                flushing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prev_reg <= sample;
        end
        if (s_fire && end_item) begin
            flush_d_reg    <= lim;
            flush_j_reg    <= count_reg;
            flush_away_reg <= away;
            flush_taps_reg <= taps;
        end else if (flush_fire) begin
            flush_d_reg <= d_m1;
        end
    end

    // Two-entry output queue: a finished verdict can wait while a sample enters.
    assign wr_idx = head_reg ^ qcnt_reg[0];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_pos_reg[wr_idx]  <= push_pos;
            q_peak_reg[wr_idx] <= push_peak;
            q_fin_reg[wr_idx]  <= push_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b0;
            qcnt_reg <= 2'd0;
        end else begin
            if (m_fire) begin
                head_reg <= ~head_reg;
            end
            qcnt_reg <= qcnt_reg + {1'b0, push} - {1'b0, m_fire};
        end
    end

    assign m_tvalid = (qcnt_reg != 2'd0);
    assign m_tdata  = {{(M_TDATA_W - POS_W - 1){1'b0}}, q_peak_reg[head_reg],
                       q_pos_reg[head_reg]};
    assign m_tlast  = q_fin_reg[head_reg];

    // The queue never holds more than two verdicts.
    a_qcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg != 2'd3)
        else $error("output queue count out of range");

    // No sample is taken while a flush is running.
    a_no_accept_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        flushing_reg |-> !s_tready)
        else $error("sample accepted during flush");

    // An end-of-profile sample always starts a flush.
    a_end_starts_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && end_item) |=> (flushing_reg && count_reg == '0))
        else $error("end of profile did not start a flush");

    // A flush never starts deeper than the largest window.
    a_flush_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        flushing_reg |-> (flush_d_reg <= WW'(MAX_WINDOW)))
        else $error("flush depth beyond window");

endmodule

// ===== rtl/core/wsed_cell.sv =====
`timescale 1ns / 1ps
// One stage of the left-verdict delay line: holds one verdict bit.
// Depends on wsed_pkg for the chain control struct.
module wsed_cell import wsed_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_ctl_t ctl,
    input  logic       d_in,
    output logic       q_out
);

    logic bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else if (ctl.clear) begin
            bit_reg <= 1'b0;
        end else if (ctl.shift) begin
            bit_reg <= d_in;
        end
    end

    assign q_out = bit_reg;

endmodule

// ===== rtl/core/wsed_chain.sv =====
`timescale 1ns / 1ps
// Row of wsed_cell stages holding the left verdicts of the newest positions.
// Depends on wsed_pkg and wsed_cell.
module wsed_chain import wsed_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chain_ctl_t            ctl,
    input  logic                  left_in,
    output logic [MAX_WINDOW-1:0] taps
);

    logic [MAX_WINDOW:0] link;

    assign link[0] = left_in;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        wsed_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .d_in    (link[k]),
            .q_out   (link[k+1])
        );
    end

    assign taps = link[MAX_WINDOW:1];

endmodule
